@@ design/psee_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psee_pkg
// Shared types and constants for the per-source offset estimator.
// ----------------------------------------------------------------------------
package psee_pkg;

   localparam int Entries   = 16;
   localparam int EmaWindow = 16;
   localparam int IdxW      = (Entries > 1) ? $clog2(Entries) : 1;
   localparam int AlphaQ16  = (2 * 65536 + (EmaWindow + 1) / 2) / (EmaWindow + 1);
   localparam int DivW      = 33;
   localparam int DivCntW   = $clog2(DivW + 1);
   // warm-up divisor n+1 never exceeds the window
   localparam int DvsW      = $clog2(EmaWindow + 1);

   typedef enum logic [1:0] {
      REQ_SLOT = 2'd0,
      REQ_SAMPLE = 2'd1,
      REQ_GEN = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_MIN_SAMPLES = 2'd0,
      CSR_MAX_SLOT_GAP = 2'd1,
      CSR_MAX_ABS_OFFSET = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [31:0]        slot_number;
      logic [15:0]        source_id;
      logic signed [31:0] offset_sample;
      logic [31:0]        generation;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               ready_res;
      logic               reset_seen;
      logic signed [31:0] raw_echo;
      logic signed [31:0] estimate;
      logic signed [31:0] applied_offset;
      logic [15:0]        count;
   } rsp_type;

   // entry word kept in the table memory
   typedef struct packed {
      logic [15:0]        source;
      logic signed [31:0] estimate;
      logic [15:0]        count;
   } entry_type;

endpackage

@@ design/per_source_ema_estimator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_ema_estimator_core
// Per-source smoothed clock offset estimator with a table memory.
// ----------------------------------------------------------------------------
// A sample of a known source scans the table, reads its entry, updates it (via
// the serial divider in warm-up) and writes it back; a new source takes a free
// entry; an oversized sample, or one with the table full, is rejected. Slot and
// generation requests give no response and may start a table clear. One request
// at a time: the next is taken only in idle with no response waiting.
// Reset: clears control state and sweeps the table.
// ----------------------------------------------------------------------------
module per_source_ema_estimator_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  psee_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output psee_pkg::rsp_type     rsp_data,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wr_data
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN, ST_SCAN_WAIT, ST_READ, ST_READ_WAIT,
      ST_CALC, ST_DIV, ST_WRITE, ST_OUT
   } state_type;

   state_type              state_ff;
   logic [6:0]             min_samples_ff;
   logic [31:0]            max_gap_ff;
   logic [30:0]            max_abs_ff;
   logic [31:0]            last_slot_ff;
   logic                   have_slot_ff, clear_pend_ff, gen_valid_ff;
   logic [31:0]            gen_ff;
   logic [psee_pkg::Entries-1:0] used_ff;
   logic [psee_pkg::IdxW-1:0] addr_ff, hit_ff, free_ff;
   logic                   hit_found_ff, free_found_ff, scan_last_ff;
   psee_pkg::req_type      req_ff;
   logic signed [31:0]     est_ff;
   logic [15:0]            cnt_ff;
   logic                   out_valid_ff;
   psee_pkg::rsp_type      out_ff;
   logic                   div_start_ff;
   logic signed [32:0]     diff_ff;
   logic signed [49:0]     prod_ff;

   // table memory port
   logic                   ram_we;
   logic [psee_pkg::IdxW-1:0] ram_addr;
   psee_pkg::entry_type    ram_wdata, ram_rdata;
   logic                   div_done;
   logic signed [32:0]     div_q;

   logic signed [32:0]     sample_ext;
   logic [31:0]            mag;
   logic [15:0]            cnt_new;
   logic                   rdy;
   psee_pkg::rsp_type      rej_rsp;

   psee_ram #(.Width($bits(psee_pkg::entry_type)), .Depth(psee_pkg::Entries)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   psee_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (diff_ff),
      .divisor  (psee_pkg::DvsW'(cnt_ff) + psee_pkg::DvsW'(1)),
      .done     (div_done),
      .quotient (div_q)
   );

   // memory access by state
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = addr_ff;
      ram_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
         end
         ST_READ: begin
            // fetch the matching entry ahead of the read wait
            ram_addr = hit_ff;
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_wdata = '{source: req_ff.source_id, estimate: est_ff, count: cnt_ff};
         end
         default: ram_we = 1'b0;
      endcase
   end

   // response for a rejected sample
   always_comb begin
      rej_rsp          = '0;
      rej_rsp.raw_echo = req_ff.offset_sample;
   end

   assign sample_ext = 33'(req_ff.offset_sample);
   assign mag        = req_ff.offset_sample[31] ? 32'(-sample_ext) : 32'(sample_ext);
   assign cnt_new    = (cnt_ff == 16'hFFFF) ? cnt_ff : cnt_ff + 16'd1;
   assign rdy        = ({9'd0, min_samples_ff} <= cnt_ff);

   assign req_stall = (state_ff != ST_IDLE) || out_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         addr_ff        <= '0;
         min_samples_ff <= 7'd8;
         max_gap_ff     <= 32'd16;
         max_abs_ff     <= 31'h7FFF_FFFF;
         last_slot_ff   <= '0;
         have_slot_ff   <= 1'b0;
         clear_pend_ff  <= 1'b1;
         gen_valid_ff   <= 1'b0;
         gen_ff         <= '0;
         used_ff        <= '0;
         out_valid_ff   <= 1'b0;
         div_start_ff   <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (csr_wr_en) begin
            case (csr_index)
               psee_pkg::CSR_MIN_SAMPLES:    min_samples_ff <= csr_wr_data[6:0];
               psee_pkg::CSR_MAX_SLOT_GAP:   max_gap_ff     <= csr_wr_data;
               psee_pkg::CSR_MAX_ABS_OFFSET: max_abs_ff     <= csr_wr_data[30:0];
               default: ;
            endcase
         end
         if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               if (addr_ff == psee_pkg::IdxW'(psee_pkg::Entries - 1)) begin
                  addr_ff  <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_valid && !req_stall) begin
                  req_ff <= req_data;
                  case (req_data.req_type)
                     psee_pkg::REQ_SLOT: begin
                        last_slot_ff <= req_data.slot_number;
                        have_slot_ff <= 1'b1;
                        if (have_slot_ff &&
                            (req_data.slot_number - last_slot_ff) > max_gap_ff) begin
                           used_ff       <= '0;
                           clear_pend_ff <= 1'b1;
                           addr_ff       <= '0;
                           state_ff      <= ST_CLEAR;
                        end
                     end
                     psee_pkg::REQ_GEN: begin
                        if (!(gen_valid_ff && gen_ff == req_data.generation)) begin
                           gen_ff        <= req_data.generation;
                           gen_valid_ff  <= 1'b1;
                           have_slot_ff  <= 1'b0;
                           clear_pend_ff <= 1'b1;
                           used_ff       <= '0;
                           addr_ff       <= '0;
                           state_ff      <= ST_CLEAR;
                        end
                     end
                     psee_pkg::REQ_SAMPLE: begin
                        addr_ff       <= '0;
                        hit_found_ff  <= 1'b0;
                        free_found_ff <= 1'b0;
                        state_ff      <= ST_SCAN;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCAN: begin
               if (mag > {1'b0, max_abs_ff}) begin
                  out_ff       <= rej_rsp;
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  scan_last_ff <= (addr_ff == psee_pkg::IdxW'(psee_pkg::Entries - 1));
                  state_ff     <= ST_SCAN_WAIT;
               end
            end
            ST_SCAN_WAIT: begin
               // each entry is addressed in the scan state and compared here
               if (used_ff[addr_ff] && ram_rdata.source == req_ff.source_id
                   && !hit_found_ff) begin
                  hit_found_ff <= 1'b1;
                  hit_ff       <= addr_ff;
               end
               if (!used_ff[addr_ff] && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_ff       <= addr_ff;
               end
               if (scan_last_ff) begin
                  state_ff <= ST_READ;
               end else begin
                  addr_ff  <= addr_ff + 1'b1;
                  state_ff <= ST_SCAN;
               end
            end
            ST_READ: begin
               if (hit_found_ff) begin
                  addr_ff  <= hit_ff;
                  state_ff <= ST_READ_WAIT;
               end else if (free_found_ff) begin
                  addr_ff           <= free_ff;
                  used_ff[free_ff]  <= 1'b1;
                  est_ff            <= '0;
                  cnt_ff            <= '0;
                  state_ff          <= ST_CALC;
               end else begin
                  out_ff       <= rej_rsp;
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_READ_WAIT: begin
               est_ff   <= ram_rdata.estimate;
               cnt_ff   <= ram_rdata.count;
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               diff_ff <= sample_ext - 33'(est_ff);
               prod_ff <= 50'(psee_pkg::AlphaQ16) * 50'(sample_ext - 33'(est_ff));
               if (cnt_ff == 16'd0) begin
                  est_ff   <= req_ff.offset_sample;
                  cnt_ff   <= cnt_new;
                  state_ff <= ST_WRITE;
               end else if (cnt_ff < 16'(psee_pkg::EmaWindow)) begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // steady rule, truncate toward zero
               est_ff <= est_ff + 32'((prod_ff + (prod_ff[49] ? 50'sd65535 : 50'sd0))
                                     >>> 16);
               cnt_ff   <= cnt_new;
               state_ff <= ST_WRITE;
            end
            ST_DIV: begin
               if (div_done) begin
                  est_ff   <= est_ff + 32'(div_q);
                  cnt_ff   <= cnt_new;
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               out_ff.accepted       <= 1'b1;
               out_ff.ready_res      <= rdy;
               out_ff.reset_seen     <= clear_pend_ff;
               out_ff.raw_echo       <= req_ff.offset_sample;
               out_ff.estimate       <= est_ff;
               out_ff.applied_offset <= rdy ? est_ff : req_ff.offset_sample;
               out_ff.count          <= cnt_ff;
               clear_pend_ff         <= 1'b0;
               out_valid_ff          <= 1'b1;
               state_ff              <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a request is never taken while a response waits
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> req_stall) else $error("request taken over pending response");
   // a response leaves only from the idle state
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> state_ff == ST_IDLE) else $error("response outside idle");
   // table writes happen only in clear or write states
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_WRITE))
      else $error("stray table write");

endmodule

@@ design/psee_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psee_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module psee_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
   input  logic [Width-1:0]                        wr_data,
   output logic [Width-1:0]                        rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // registered read, returns the old word on a write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

@@ design/psee_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psee_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module psee_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [psee_pkg::DivW-1:0]  dividend,
   input  logic [psee_pkg::DvsW-1:0]         divisor,
   output logic                              done,
   output logic signed [psee_pkg::DivW-1:0]  quotient
);

   logic [psee_pkg::DivW-1:0]    mag_ff, mag_in;
   logic [psee_pkg::DvsW:0]      rem_ff, rem_in;
   logic [psee_pkg::DivCntW-1:0] cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         neg_ff, neg_in;
   logic                         done_ff, done_in;
   logic [psee_pkg::DvsW-1:0]    dvs_ff, dvs_in;
   logic [psee_pkg::DvsW:0]      trial;

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      trial   = {rem_ff[psee_pkg::DvsW-1:0], mag_ff[psee_pkg::DivW-1]};
      // load magnitude and sign
      if (start) begin
         neg_in  = dividend[psee_pkg::DivW-1];
         mag_in  = dividend[psee_pkg::DivW-1] ? psee_pkg::DivW'(-dividend)
                                              : psee_pkg::DivW'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = psee_pkg::DivCntW'(psee_pkg::DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            mag_in = {mag_ff[psee_pkg::DivW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            mag_in = {mag_ff[psee_pkg::DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == psee_pkg::DivCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-source offset estimator. Requests come from
// a queue filled by directed and random phases, and the response monitor
// compares every response with a behavioral estimator model.
// ----------------------------------------------------------------------------
module tb_top;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   psee_pkg::req_type   req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   psee_pkg::rsp_type   rsp_data;
   logic                csr_wr_en;
   logic [1:0]          csr_index;
   logic [31:0]         csr_wr_data;

   per_source_ema_estimator_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // estimator model state
   logic               mdl_used [psee_pkg::Entries];
   logic [15:0]        mdl_source [psee_pkg::Entries];
   logic signed [31:0] mdl_estimate [psee_pkg::Entries];
   logic [15:0]        mdl_count [psee_pkg::Entries];
   logic [31:0]        mdl_last_slot;
   logic               mdl_have_slot;
   logic               mdl_clear_pending;
   logic               mdl_gen_valid;
   logic [31:0]        mdl_generation;
   logic [6:0]         cfg_min_samples;
   logic [31:0]        cfg_max_slot_gap;
   logic [30:0]        cfg_max_abs_offset;

   psee_pkg::req_type pending_reqs[$];
   psee_pkg::rsp_type expected_rsps[$];
   int      errors = 0;
   int      req_gap;
   int      rsp_gap;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("per_source_ema_estimator_core verification failed");
      $finish;
   end

   function automatic void clear_entries();
      for (int i = 0; i < psee_pkg::Entries; i++) begin
         mdl_used[i] = 1'b0;
         mdl_source[i] = '0;
         mdl_estimate[i] = '0;
         mdl_count[i] = '0;
      end
   endfunction

   // model one accepted request, queue any expected response
   function automatic void predict_request(psee_pkg::req_type r);
      psee_pkg::rsp_type  rsp;
      int                 idx;
      int                 free_idx;
      longint             x;
      longint             mag;
      longint             e;
      longint             d;
      int unsigned        n;
      logic               rdy;
      idx = -1;
      free_idx = -1;
      rsp = '0;
      case (r.req_type)
         psee_pkg::REQ_SLOT: begin
            if (mdl_have_slot && (r.slot_number - mdl_last_slot) > cfg_max_slot_gap) begin
               clear_entries();
               mdl_clear_pending = 1'b1;
            end
            mdl_last_slot = r.slot_number;
            mdl_have_slot = 1'b1;
         end
         psee_pkg::REQ_GEN: begin
            if (!(mdl_gen_valid && mdl_generation == r.generation)) begin
               clear_entries();
               mdl_generation = r.generation;
               mdl_gen_valid = 1'b1;
               mdl_have_slot = 1'b0;
               mdl_clear_pending = 1'b1;
            end
         end
         psee_pkg::REQ_SAMPLE: begin
            x = longint'(r.offset_sample);
            mag = (x < 0) ? -x : x;
            rsp.raw_echo = r.offset_sample;
            if (mag <= longint'(cfg_max_abs_offset)) begin
               for (int i = 0; i < psee_pkg::Entries; i++) begin
                  if (idx < 0 && mdl_used[i] && mdl_source[i] == r.source_id) idx = i;
                  if (!mdl_used[i] && free_idx < 0) free_idx = i;
               end
               if (idx < 0 && free_idx >= 0) begin
                  idx = free_idx;
                  mdl_used[idx] = 1'b1;
                  mdl_source[idx] = r.source_id;
                  mdl_estimate[idx] = '0;
                  mdl_count[idx] = '0;
               end
            end
            if (idx >= 0) begin
               n = mdl_count[idx];
               e = longint'(mdl_estimate[idx]);
               d = x - e;
               if (n == 0) e = x;
               else if (n < psee_pkg::EmaWindow) e = e + d / longint'(n + 1);
               else e = e + (longint'(psee_pkg::AlphaQ16) * d) / 65536;
               mdl_estimate[idx] = e[31:0];
               if (n < 65535) n++;
               mdl_count[idx] = n[15:0];
               rdy = (n >= cfg_min_samples);
               rsp.accepted = 1'b1;
               rsp.ready_res = rdy;
               rsp.reset_seen = mdl_clear_pending;
               mdl_clear_pending = 1'b0;
               rsp.estimate = e[31:0];
               rsp.applied_offset = rdy ? e[31:0] : r.offset_sample;
               rsp.count = n[15:0];
            end
            expected_rsps.push_back(rsp);
         end
         default: ;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
         clear_entries();
         mdl_last_slot = '0;
         mdl_have_slot = 1'b0;
         mdl_clear_pending = 1'b1;
         mdl_gen_valid = 1'b0;
         mdl_generation = '0;
      end else if (req_valid && !req_stall) begin
         predict_request(req_data);
         void'(pending_reqs.pop_front());
         req_gap <= $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
         req_valid <= 1'b0;
      end else if (!req_valid) begin
         if (req_gap > 0) req_gap <= req_gap - 1;
         else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs[0];
            req_valid <= 1'b1;
         end
      end
   end

   // response monitor with random stall
   always @(posedge clock) begin
      psee_pkg::rsp_type exp_rsp;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t unexpected response %h", $time, rsp_data);
               errors++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_data !== exp_rsp) begin
                  $display("%0t mismatch expected %p actual %p", $time, exp_rsp, rsp_data);
                  errors++;
               end
            end
            rsp_gap <= $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add_slot(logic [31:0] slot);
      psee_pkg::req_type r;
      r = '0;
      r.req_type = psee_pkg::REQ_SLOT;
      r.slot_number = slot;
      pending_reqs.push_back(r);
   endtask

   task automatic add_gen(logic [31:0] g);
      psee_pkg::req_type r;
      r = '0;
      r.req_type = psee_pkg::REQ_GEN;
      r.generation = g;
      pending_reqs.push_back(r);
   endtask

   task automatic add_sample(logic [15:0] src, logic [31:0] x);
      psee_pkg::req_type r;
      r = '0;
      r.req_type = psee_pkg::REQ_SAMPLE;
      r.source_id = src;
      r.offset_sample = x;
      pending_reqs.push_back(r);
   endtask

   // wait for all requests and responses to drain, then let the block settle
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(psee_pkg::csr_index_type idx, logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         psee_pkg::CSR_MIN_SAMPLES: cfg_min_samples = val[6:0];
         psee_pkg::CSR_MAX_SLOT_GAP: cfg_max_slot_gap = val;
         psee_pkg::CSR_MAX_ABS_OFFSET: cfg_max_abs_offset = val[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // random content with a small pool of sources so entries get reused
   task automatic random_phase(int num, int src_span);
      psee_pkg::req_type r;
      logic [31:0] slot;
      int kind;
      slot = $urandom;
      for (int i = 0; i < num; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            slot = ($urandom_range(0, 3) == 0) ? $urandom : slot + $urandom_range(0, 20);
            add_slot(slot);
         end else if (kind < 11) begin
            add_gen($urandom_range(0, 3));
         end else if (kind < 13) begin
            r = '0;
            r.req_type = psee_pkg::REQ_NONE;
            r.slot_number = $urandom;
            r.source_id = 16'($urandom);
            r.offset_sample = $urandom;
            r.generation = $urandom;
            pending_reqs.push_back(r);
         end else begin
            case ($urandom_range(0, 3))
               0: add_sample(16'($urandom_range(0, src_span)), $urandom);
               1: add_sample(16'($urandom_range(0, src_span)),
                             $urandom_range(0, 4000) - 2000);
               2: add_sample(16'($urandom), $urandom >> $urandom_range(0, 31));
               default: add_sample(16'($urandom_range(0, src_span)),
                                   -($urandom >> $urandom_range(1, 31)));
            endcase
         end
      end
   endtask

   // stimulus
   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      cfg_min_samples = 7'd8;
      cfg_max_slot_gap = 32'd16;
      cfg_max_abs_offset = 31'h7fffffff;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, warm-up, reject, slot gap and generation cases
      add_sample(16'hffff, 32'h7fffffff);
      add_sample(16'hffff, 32'h80000000);
      add_sample(16'hffff, 32'h80000001);
      add_sample(16'h0000, 32'h0);
      for (int i = 0; i < 18; i++) add_sample(16'h0000, (i % 2) ? 32'hfff00000 : 32'h00100000);
      add_slot(32'hffffffff);
      add_slot(32'd15);
      add_slot(32'd100);
      add_sample(16'h0001, 32'd5);
      add_gen(32'hffffffff);
      add_gen(32'hffffffff);
      add_gen(32'h0);
      add_sample(16'h0001, 32'd7);
      // fill the table then overflow it
      for (int i = 0; i < psee_pkg::Entries + 1; i++) add_sample(16'(i + 'h100), -i);
      drain();

      write_csr(psee_pkg::CSR_MIN_SAMPLES, 32'd0);
      write_csr(psee_pkg::CSR_MAX_SLOT_GAP, 32'd0);
      write_csr(psee_pkg::CSR_MAX_ABS_OFFSET, 32'd0);
      add_sample(16'h0200, 32'd0);
      add_sample(16'h0200, 32'd1);
      random_phase(200, 20);
      drain();

      write_csr(psee_pkg::CSR_MIN_SAMPLES, 32'd64);
      write_csr(psee_pkg::CSR_MAX_SLOT_GAP, 32'hffffffff);
      write_csr(psee_pkg::CSR_MAX_ABS_OFFSET, 32'h7fffffff);
      // long run on one source to exercise steady state and count growth
      for (int i = 0; i < 150; i++) add_sample(16'h0042, $urandom);
      random_phase(300, 10);
      drain();

      for (int p = 0; p < 4; p++) begin
         write_csr(psee_pkg::CSR_MIN_SAMPLES, $urandom_range(1, 64));
         write_csr(psee_pkg::CSR_MAX_SLOT_GAP, $urandom_range(0, 40));
         write_csr(psee_pkg::CSR_MAX_ABS_OFFSET,
                   ($urandom_range(0, 1)) ? 32'h7fffffff : $urandom >> 1);
         random_phase(215, 12 + 8 * p);
         drain();
      end

      if (errors == 0) begin
         $display("per_source_ema_estimator_core verification clean");
      end else begin
         $display("per_source_ema_estimator_core verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/psee_pkg.sv
design/psee_ram.sv
design/psee_div.sv
design/per_source_ema_estimator_core.sv
verif/tb_top.sv
